>>> rtl/rtt_retransmit_timeout_table_assert.svh
// Assertion macros shared by the retransmit-timeout table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RTT_RETRANSMIT_TIMEOUT_TABLE_ASSERT_SVH
`define RTT_RETRANSMIT_TIMEOUT_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtt assertion failed");

// Next-cycle implication, checked outside reset.
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtt assertion failed");

`endif

>>> rtl/rtt_pkg.sv
// Shared types and constants of the retransmit-timeout table.
// No dependencies; used by rtt_ctrl, rtt_datapath and the top level.
package rtt_pkg;

  localparam int DESTINATIONS = 64;
  localparam int DEST_W       = $clog2(DESTINATIONS);

  localparam int RTO_W   = 16;
  localparam int ALLOW_W = 8;
  localparam int SRTT_W  = 19;
  localparam int DEV_W   = 18;
  localparam int RTT_W   = 17;
  localparam int SUM_W   = 19;
  localparam int CFG_IDX_W = 2;

  localparam logic [RTO_W-1:0]   MIN_RTO_RST = 16'd500;
  localparam logic [RTO_W-1:0]   MAX_RTO_RST = 16'd5000;
  localparam logic [ALLOW_W-1:0] ALLOW_RST   = 8'd10;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SEND    = 2'd0;
  localparam kind_t KIND_SAMPLE  = 2'd1;
  localparam kind_t KIND_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FIRST, S_ERR, S_UPD, S_DEV, S_SUM, S_DBL, S_CLAMP, S_WRITE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD, OP_FIRST, OP_ERR, OP_UPD, OP_DEV, OP_SUM,
    OP_DBL, OP_CLAMP, OP_WRITE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  rtt_neg;
    logic  measured;
  } dp_status_t;

  typedef struct packed {
    logic [SRTT_W-1:0] srtt;
    logic [DEV_W-1:0]  dev;
    logic [RTO_W-1:0]  rto;
  } rec_t;

endpackage

>>> rtl/rtt_ctrl.sv
// Controller state machine of the retransmit-timeout table.
// Depends on rtt_pkg and rtt_retransmit_timeout_table_assert.svh.
`include "rtt_retransmit_timeout_table_assert.svh"

module rtt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rtt_pkg::dp_status_t status,
  output rtt_pkg::dp_cmd_t    cmd
);

  rtt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtt_pkg::S_IDLE:  if (in_valid) state_nxt = rtt_pkg::S_LOAD;
      rtt_pkg::S_LOAD: begin
        if (status.kind == rtt_pkg::KIND_SAMPLE && !status.rtt_neg) begin
          state_nxt = status.measured ? rtt_pkg::S_ERR : rtt_pkg::S_FIRST;
        end else if (status.kind == rtt_pkg::KIND_TIMEOUT) begin
          state_nxt = rtt_pkg::S_DBL;
        end else begin
          state_nxt = rtt_pkg::S_WRITE;
        end
      end
      rtt_pkg::S_FIRST: state_nxt = rtt_pkg::S_CLAMP;
      rtt_pkg::S_ERR:   state_nxt = rtt_pkg::S_UPD;
      rtt_pkg::S_UPD:   state_nxt = rtt_pkg::S_DEV;
      rtt_pkg::S_DEV:   state_nxt = rtt_pkg::S_SUM;
      rtt_pkg::S_SUM:   state_nxt = rtt_pkg::S_CLAMP;
      rtt_pkg::S_DBL:   state_nxt = rtt_pkg::S_CLAMP;
      rtt_pkg::S_CLAMP: state_nxt = rtt_pkg::S_WRITE;
      rtt_pkg::S_WRITE: if (out_free) state_nxt = rtt_pkg::S_IDLE;
      default:          state_nxt = rtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = rtt_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      rtt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = rtt_pkg::OP_ACCEPT;
      end
      rtt_pkg::S_LOAD:  cmd.op = rtt_pkg::OP_LOAD;
      rtt_pkg::S_FIRST: cmd.op = rtt_pkg::OP_FIRST;
      rtt_pkg::S_ERR:   cmd.op = rtt_pkg::OP_ERR;
      rtt_pkg::S_UPD:   cmd.op = rtt_pkg::OP_UPD;
      rtt_pkg::S_DEV:   cmd.op = rtt_pkg::OP_DEV;
      rtt_pkg::S_SUM:   cmd.op = rtt_pkg::OP_SUM;
      rtt_pkg::S_DBL:   cmd.op = rtt_pkg::OP_DBL;
      rtt_pkg::S_CLAMP: cmd.op = rtt_pkg::OP_CLAMP;
      rtt_pkg::S_WRITE: begin
        if (out_free) begin
          cmd.op        = rtt_pkg::OP_WRITE;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = rtt_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A transfer in always starts the record load.
  `RTT_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && in_ready, state_r == rtt_pkg::S_LOAD)
  // A result only appears from the write-back step.
  `RTT_ASSERT_NOW(a_result_from_write, clk, rst_n, $rose(out_valid_r), $past(state_r) == rtt_pkg::S_WRITE)
  // Write-back with a free output register always presents a result.
  `RTT_ASSERT_NEXT(a_write_presents, clk, rst_n, state_r == rtt_pkg::S_WRITE && out_free, out_valid_r && state_r == rtt_pkg::S_IDLE)

endmodule

>>> rtl/rtt_datapath.sv
// Datapath of the retransmit-timeout table: record memory, estimator
// arithmetic, configuration registers and result register. Depends on rtt_pkg.
module rtt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtt_pkg::dp_cmd_t                cmd,
  output rtt_pkg::dp_status_t             status,
  input  logic [1:0]                      in_kind,
  input  logic [5:0]                      in_dest,
  input  logic signed [16:0]              in_rtt_ms,
  input  logic                            cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wdata,
  output logic [15:0]                     out_rto_ms,
  output logic                            out_estimate_ready
);

  localparam int DW = rtt_pkg::DEST_W;

  // Configuration registers.
  logic [rtt_pkg::RTO_W-1:0]   min_rto_r, max_rto_r;
  logic [rtt_pkg::ALLOW_W-1:0] allow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rto_r <= rtt_pkg::MIN_RTO_RST;
      max_rto_r <= rtt_pkg::MAX_RTO_RST;
      allow_r   <= rtt_pkg::ALLOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rtt_pkg::CFG_MIN_RTO: min_rto_r <= cfg_wdata;
        rtt_pkg::CFG_MAX_RTO: max_rto_r <= cfg_wdata;
        rtt_pkg::CFG_ALLOW:   allow_r   <= cfg_wdata[rtt_pkg::ALLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Record memory and per-entry flags.
  rtt_pkg::rec_t mem [rtt_pkg::DESTINATIONS];
  logic [rtt_pkg::DESTINATIONS-1:0] known_r, measured_r;

  rtt_pkg::rec_t rd_r;
  logic          known_rd_r, meas_rd_r;

  rtt_pkg::kind_t           kind_r;
  logic [DW-1:0]            dest_r;
  logic [rtt_pkg::RTT_W-1:0] rtt_r;

  logic [rtt_pkg::SRTT_W-1:0]  srtt_r;
  logic [rtt_pkg::DEV_W-1:0]   dev_r;
  logic [rtt_pkg::RTO_W-1:0]   rto_r;
  logic                        meas_r;
  logic signed [16:0]          err_r;
  logic [15:0]                 mag_r;
  logic [rtt_pkg::SUM_W-1:0]   v_r;

  logic [15:0] m;
  logic [15:0] srtt_mean;
  assign m         = rtt_r[15:0];
  assign srtt_mean = srtt_r[rtt_pkg::SRTT_W-1:3];

  always_ff @(posedge clk) begin
    if (cmd.op == rtt_pkg::OP_ACCEPT) begin
      rd_r <= mem[in_dest[DW-1:0]];
    end
    if (cmd.op == rtt_pkg::OP_WRITE) begin
      mem[dest_r] <= '{srtt: srtt_r, dev: dev_r, rto: rto_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r    <= '0;
      measured_r <= '0;
    end else if (cmd.op == rtt_pkg::OP_WRITE) begin
      known_r[dest_r]    <= 1'b1;
      measured_r[dest_r] <= meas_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rtt_pkg::OP_ACCEPT: begin
        kind_r     <= in_kind;
        dest_r     <= in_dest[DW-1:0];
        rtt_r      <= in_rtt_ms;
        known_rd_r <= known_r[in_dest[DW-1:0]];
        meas_rd_r  <= measured_r[in_dest[DW-1:0]];
      end
      rtt_pkg::OP_LOAD: begin
        // A fresh record starts at max_rto, unclamped.
        srtt_r <= rd_r.srtt;
        dev_r  <= rd_r.dev;
        rto_r  <= known_rd_r ? rd_r.rto : max_rto_r;
        meas_r <= known_rd_r && meas_rd_r;
      end
      rtt_pkg::OP_FIRST: begin
        srtt_r <= {m, 3'b000};
        dev_r  <= '0;
        meas_r <= 1'b1;
        v_r    <= rtt_pkg::SUM_W'({m, 2'b00}) + rtt_pkg::SUM_W'(allow_r);
      end
      rtt_pkg::OP_ERR: begin
        err_r <= $signed({1'b0, m}) - $signed({1'b0, srtt_mean});
      end
      rtt_pkg::OP_UPD: begin
        srtt_r <= srtt_r + rtt_pkg::SRTT_W'(unsigned'(rtt_pkg::SRTT_W'(err_r)));
        mag_r  <= err_r[16] ? 16'(-err_r) : err_r[15:0];
      end
      rtt_pkg::OP_DEV: begin
        dev_r <= dev_r + rtt_pkg::DEV_W'(mag_r) - (dev_r >> 2);
      end
      rtt_pkg::OP_SUM: begin
        v_r <= rtt_pkg::SUM_W'(srtt_mean) + rtt_pkg::SUM_W'(dev_r)
             + rtt_pkg::SUM_W'(allow_r);
      end
      rtt_pkg::OP_DBL: begin
        v_r <= rtt_pkg::SUM_W'({rto_r, 1'b0});
      end
      rtt_pkg::OP_CLAMP: begin
        if (v_r > rtt_pkg::SUM_W'(max_rto_r)) begin
          rto_r <= max_rto_r;
        end else if (v_r < rtt_pkg::SUM_W'(min_rto_r)) begin
          rto_r <= min_rto_r;
        end else begin
          rto_r <= v_r[rtt_pkg::RTO_W-1:0];
        end
      end
      rtt_pkg::OP_WRITE: begin
        out_rto_ms         <= rto_r;
        out_estimate_ready <= meas_r;
      end
      default: ;
    endcase
  end

  assign status.kind     = kind_r;
  assign status.rtt_neg  = rtt_r[rtt_pkg::RTT_W-1];
  assign status.measured = known_rd_r && meas_rd_r;

endmodule

>>> rtl/rtt_retransmit_timeout_table.sv
// Top level of the per-destination retransmit-timeout table.
// Depends on rtt_pkg, rtt_ctrl and rtt_datapath.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -----------------------
//  input     in_kind, in_dest, in_rtt_ms             in_valid / in_ready
//  result    out_rto_ms, out_estimate_ready          out_valid / out_ready
//  config    cfg_index, cfg_wdata                    cfg_we (no wait)
//
// After its transfer in, an event is loaded and then goes straight to write-back for a
// send query, the unused kind or an ignored sample; a first sample takes a first-sample
// step and a clamp, a timeout a doubling step and a clamp, and a later sample the error,
// update, deviation, sum and clamp steps. The block takes a new event only from idle.
// Reset is synchronous and clears all records at once through per-entry flags.
// A stalled result waits in the output register; the next event is already
// taken in and worked on, and only its write-back waits for that register.
module rtt_retransmit_timeout_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input events.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [5:0]                    in_dest,
  input  logic signed [16:0]            in_rtt_ms,
  // Results.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_rto_ms,
  output logic                          out_estimate_ready,
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  // Commands from the controller and status back from the datapath.
  rtt_pkg::dp_cmd_t    cmd;
  rtt_pkg::dp_status_t status;

  // The controller steps each event through load, the estimator update and clamp for
  // accepted samples and timeouts, and write-back, and owns the result valid flag.
  rtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the records, the configuration and the result register.
  rtt_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (in_kind),
    .in_dest            (in_dest),
    .in_rtt_ms          (in_rtt_ms),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_rto_ms         (out_rto_ms),
    .out_estimate_ready (out_estimate_ready)
  );

endmodule

>>> dv/rtt_retransmit_timeout_table_tb.sv
// Testbench for the per-destination retransmit-timeout table.
// Needs rtt_pkg and the rtt_retransmit_timeout_table RTL. Directed and random events are
// checked against a behavioral estimator that runs in step with the block.
module rtt_retransmit_timeout_table_tb;

  // Kind code 3 is not a defined event. The block treats it as a send query.
  localparam rtt_pkg::kind_t KIND_UNUSED = 2'd3;

  // Watchdog limit, counted in cycles with no transfer on either channel. The worst
  // correct case is a later sample behind a receiver that stalls 62 percent of the
  // time, so this limit is far beyond anything a working block needs.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last result.
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_LIMIT = 40;

  // One expected result: the destination's timeout and its estimate flag.
  typedef struct packed {
    logic [rtt_pkg::RTO_W-1:0] rto;
    logic                      ready;
  } rto_expect_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  rtt_pkg::kind_t                   in_kind = rtt_pkg::KIND_SEND;
  logic [rtt_pkg::DEST_W-1:0]       in_dest = '0;
  logic signed [rtt_pkg::RTT_W-1:0] in_rtt_ms = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [rtt_pkg::RTO_W-1:0]        out_rto_ms;
  logic                             out_estimate_ready;
  logic                             cfg_we = 1'b0;
  logic [rtt_pkg::CFG_IDX_W-1:0]    cfg_index = rtt_pkg::CFG_MIN_RTO;
  logic [rtt_pkg::RTO_W-1:0]        cfg_wdata = '0;

  rtt_retransmit_timeout_table uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_dest            (in_dest),
    .in_rtt_ms          (in_rtt_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rto_ms         (out_rto_ms),
    .out_estimate_ready (out_estimate_ready),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The estimator's own copy of the table. It follows the block one accepted event at a
  // time. Each timeout is written when its destination is first touched, and the mean and
  // deviation at its first measurement, so their undefined reset contents are never read.
  logic                        known_q    [rtt_pkg::DESTINATIONS];
  logic                        measured_q [rtt_pkg::DESTINATIONS];
  logic [rtt_pkg::SRTT_W-1:0]  srtt_q     [rtt_pkg::DESTINATIONS];
  logic [rtt_pkg::DEV_W-1:0]   dev_q      [rtt_pkg::DESTINATIONS];
  logic [rtt_pkg::RTO_W-1:0]   rto_q      [rtt_pkg::DESTINATIONS];
  logic [rtt_pkg::RTO_W-1:0]   min_rto_q = rtt_pkg::MIN_RTO_RST;
  logic [rtt_pkg::RTO_W-1:0]   max_rto_q = rtt_pkg::MAX_RTO_RST;
  logic [rtt_pkg::ALLOW_W-1:0] allow_q   = rtt_pkg::ALLOW_RST;

  rto_expect_t pending_rto_q[$];
  rto_expect_t next_rto;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int events_sent = 0;
  int results_checked = 0;
  int limit_loads = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < rtt_pkg::DESTINATIONS; i++) begin
      known_q[i] = 1'b0;
      measured_q[i] = 1'b0;
    end
  end

  // Clamp order follows the block: the upper limit is tested first. When min_rto is
  // above max_rto, a large value therefore still ends up at max_rto.
  function automatic int clamp_rto(input int v);
    int lo;
    int hi;
    lo = int'(min_rto_q);
    hi = int'(max_rto_q);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Apply one accepted event to the table copy and queue the result it must produce.
  task automatic estimate_event(input rtt_pkg::kind_t kind,
                                input logic [rtt_pkg::DEST_W-1:0] dest,
                                input logic signed [rtt_pkg::RTT_W-1:0] rtt);
    int d;
    int m;
    int err;
    int mag;
    int mean;
    int dev;
    int v;
    rto_expect_t r;
    d = int'(dest);
    m = int'(rtt[rtt_pkg::RTT_W-2:0]);
    // A destination seen for the first time starts at max_rto. That value is not
    // clamped, even when it is below min_rto.
    if (!known_q[d]) begin
      known_q[d] = 1'b1;
      measured_q[d] = 1'b0;
      rto_q[d] = max_rto_q;
    end
    // A sample with the sign bit set carries no measurement and is dropped.
    if (kind == rtt_pkg::KIND_SAMPLE && !rtt[rtt_pkg::RTT_W-1]) begin
      if (!measured_q[d]) begin
        // First measurement: the mean is set to the sample, the deviation is zero.
        measured_q[d] = 1'b1;
        srtt_q[d] = rtt_pkg::SRTT_W'(m * 8);
        dev_q[d] = '0;
        v = 4 * m + int'(allow_q);
      end else begin
        // The mean is kept times 8 and the deviation times 4. Each moves by its error
        // term, and both wrap at their storage widths.
        mean = int'(srtt_q[d]);
        dev = int'(dev_q[d]);
        err = m - (mean >>> 3);
        mag = (err < 0) ? -err : err;
        srtt_q[d] = rtt_pkg::SRTT_W'(mean + err);
        dev_q[d] = rtt_pkg::DEV_W'(dev + mag - (dev >>> 2));
        mean = int'(srtt_q[d]);
        dev = int'(dev_q[d]);
        v = (mean >>> 3) + dev + int'(allow_q);
      end
      rto_q[d] = rtt_pkg::RTO_W'(clamp_rto(v));
    end else if (kind == rtt_pkg::KIND_TIMEOUT) begin
      v = int'(rto_q[d]);
      rto_q[d] = rtt_pkg::RTO_W'(clamp_rto(2 * v));
    end
    // Send queries and the unused kind only report the stored timeout.
    r.rto = rto_q[d];
    r.ready = measured_q[d];
    pending_rto_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // The receiver stalls at random according to the current regime.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Transfer monitor. It predicts on input transfers and checks on result transfers,
  // always in that order. The watchdog is also here. Every value read was settled
  // before this edge, because the testbench and the block both assign through
  // nonblocking updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        estimate_event(in_kind, in_dest, in_rtt_ms);
      if (out_valid && out_ready) begin
        if (pending_rto_q.size() == 0) begin
          report_mismatch("result with no event pending", int'(out_rto_ms), -1);
        end else begin
          next_rto = pending_rto_q.pop_front();
          if (out_rto_ms !== next_rto.rto)
            report_mismatch("rto_ms", int'(out_rto_ms), int'(next_rto.rto));
          if (out_estimate_ready !== next_rto.ready)
            report_mismatch("estimate_ready", int'(out_estimate_ready),
                            int'(next_rto.ready));
        end
        results_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_rto_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one event and hold it until it is taken. A random gap may come before it.
  // Valid stays high into the next call, so back-to-back events never drop it.
  task automatic send_event(input rtt_pkg::kind_t kind,
                            input logic [rtt_pkg::DEST_W-1:0] dest,
                            input logic signed [rtt_pkg::RTT_W-1:0] rtt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_dest <= dest;
    in_rtt_ms <= rtt;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  // Hold the sender off until every expected result has come back. Always wait on the
  // clock, so that valid is never lowered and raised in the same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rto_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Write all three limit registers. The block is drained first, so no event is in
  // flight while the limits change.
  task automatic load_timeout_limits(input logic [rtt_pkg::RTO_W-1:0] lo,
                                     input logic [rtt_pkg::RTO_W-1:0] hi,
                                     input logic [rtt_pkg::ALLOW_W-1:0] allow);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= rtt_pkg::CFG_MIN_RTO;
    cfg_wdata <= lo;
    @(posedge clk);
    min_rto_q = lo;
    cfg_index <= rtt_pkg::CFG_MAX_RTO;
    cfg_wdata <= hi;
    @(posedge clk);
    max_rto_q = hi;
    cfg_index <= rtt_pkg::CFG_ALLOW;
    cfg_wdata <= rtt_pkg::RTO_W'(allow);
    @(posedge clk);
    allow_q = allow;
    cfg_we <= 1'b0;
    limit_loads++;
  endtask

  // Destinations that have not been touched yet, under the reset limits. Covers a query,
  // a timeout, a dropped sample and the unused kind, on both ends of the index range.
  task automatic test_fresh_records();
    send_event(rtt_pkg::KIND_SEND, 6'd0, 17'sd0);
    send_event(rtt_pkg::KIND_TIMEOUT, 6'd1, 17'sd0);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd2, -17'sd1);
    send_event(KIND_UNUSED, 6'd63, 17'h10000);
  endtask

  // First and later samples, a dropped sample on a measured record, a timeout doubling,
  // and the extreme sample values.
  task automatic test_sample_updates();
    send_event(rtt_pkg::KIND_SAMPLE, 6'd3, 17'sd100);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd4, 17'sd1000);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd4, 17'sd1200);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd4, -17'sd5);
    send_event(rtt_pkg::KIND_TIMEOUT, 6'd4, 17'sd0);
    send_event(rtt_pkg::KIND_SEND, 6'd4, 17'h1ffff);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd4, 17'sd0);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd5, 17'sd65535);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd5, 17'sd0);
  endtask

  // The widest limits with the largest allowance. Then inverted limits with no
  // allowance: a fresh record keeps max_rto even below min_rto, and values above the
  // upper limit win over the lower one.
  task automatic test_clamp_extremes();
    load_timeout_limits(16'd1, 16'd65535, 8'd255);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd6, 17'sd0);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd6, 17'sd65535);
    send_event(rtt_pkg::KIND_TIMEOUT, 6'd6, 17'sd0);
    send_event(rtt_pkg::KIND_TIMEOUT, 6'd6, 17'sd0);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd7, 17'sd65535);
    load_timeout_limits(16'd65535, 16'd1, 8'd0);
    send_event(rtt_pkg::KIND_SEND, 6'd8, 17'sd0);
    send_event(rtt_pkg::KIND_TIMEOUT, 6'd8, 17'sd0);
    send_event(rtt_pkg::KIND_SAMPLE, 6'd8, 17'sd0);
    send_event(rtt_pkg::KIND_SEND, 6'd6, 17'sd0);
  endtask

  // Random traffic under one flow-control regime. Samples are the most common kind and
  // mostly carry plausible round trips, so the estimator builds real history. About a
  // quarter of events hit a small group of destinations to drive longer histories.
  // Full-range, extreme and negative samples are mixed in. Halfway through, the limits
  // are reloaded with random values, and the sender sometimes waits for a full drain.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count,
                                     input logic [rtt_pkg::RTO_W-1:0] lo,
                                     input logic [rtt_pkg::RTO_W-1:0] hi,
                                     input logic [rtt_pkg::ALLOW_W-1:0] allow);
    int n;
    int pick;
    rtt_pkg::kind_t kind;
    logic [rtt_pkg::DEST_W-1:0] dest;
    logic [rtt_pkg::DEST_W-1:0] hot_base;
    logic signed [rtt_pkg::RTT_W-1:0] rtt;
    load_timeout_limits(lo, hi, allow);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hot_base = rtt_pkg::DEST_W'($urandom);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30)
        kind = rtt_pkg::KIND_SEND;
      else if (pick < 75)
        kind = rtt_pkg::KIND_SAMPLE;
      else if (pick < 94)
        kind = rtt_pkg::KIND_TIMEOUT;
      else
        kind = KIND_UNUSED;
      if ($urandom_range(99) < 25)
        dest = hot_base + rtt_pkg::DEST_W'($urandom_range(7));
      else
        dest = rtt_pkg::DEST_W'($urandom);
      pick = $urandom_range(99);
      if (kind != rtt_pkg::KIND_SAMPLE || pick < 8)
        rtt = {1'b1, 16'($urandom)};
      else if (pick < 20)
        rtt = {1'b0, 16'($urandom)};
      else if (pick < 25)
        rtt = $urandom_range(1) ? 17'sd65535 : 17'sd0;
      else
        rtt = rtt_pkg::RTT_W'($urandom_range(1500, 20));
      // For kinds other than a sample the field does not matter, so half the time it
      // takes any value at all.
      if (kind != rtt_pkg::KIND_SAMPLE && $urandom_range(1))
        rtt = {1'b0, 16'($urandom)};
      send_event(kind, dest, rtt);
      if ($urandom_range(199) == 0)
        drain_results();
      if (n == count / 2)
        load_timeout_limits(16'($urandom_range(2000, 1)), 16'($urandom_range(65535, 1000)),
                            8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 7;
    recv_stall_pct = 62;
    test_fresh_records();
    test_sample_updates();
    test_clamp_extremes();
    test_random_traffic(7, 62, 550, 16'd200, 16'd8000, 8'd10);
    test_random_traffic(62, 7, 550, 16'd1, 16'd65535, 8'd255);
    test_random_traffic(0, 0, 550, 16'd300, 16'd3000, 8'd0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d events and %0d results over three flow-control regimes, %0d limit loads",
             events_sent, results_checked, limit_loads);
    $display("covered fresh records, samples, drops, timeouts, inverted limits; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_ctrl.sv
rtl/rtt_datapath.sv
rtl/rtt_retransmit_timeout_table.sv
dv/rtt_retransmit_timeout_table_tb.sv
